@@ src/gaas_pkg.sv @@
// Shared types, constants and saturation helpers for the gather / scatter-add slab block.
package gaas_pkg;

  localparam int SLAB_DEPTH = 4096;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(SLAB_DEPTH);

  localparam int CFG_W  = 13;
  localparam int POS_W  = 12;
  localparam int IDX_W  = 12;
  localparam int VAL_W  = 32;
  localparam int OUT_W  = 32;
  localparam int PROD_W = CFG_W + CFG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int EXT_W  = ((DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W) + 1;

  localparam int IN_DATA_W  = ((POS_W + IDX_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int  REG_IDX_W     = 1;
  localparam logic [REG_IDX_W-1:0] REG_POST_SIZE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_AXIS_SIZE = 1'b1;

  localparam logic signed [EXT_W-1:0] DW_MAX = EXT_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [EXT_W-1:0] DW_MIN = -DW_MAX - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] OW_MAX = EXT_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [EXT_W-1:0] OW_MIN = -OW_MAX - EXT_W'(1);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_GATHER = 2'd1,
    OP_ACCUM  = 2'd2,
    OP_DRAIN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_AXIS_BAD = 2'd1,
    ST_POS_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_CHK,
    S_MOD
  } state_t;

  typedef struct packed {
    op_t                     op;
    logic [POS_W-1:0]        position;
    logic [IDX_W-1:0]        axis_index;
    logic signed [VAL_W-1:0] value;
  } item_t;

  // address unit result: slab address and range status
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } chk_t;

  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [EXT_W-1:0] x);
    if (x > DW_MAX)      sat_dw = DW_MAX[DATA_WIDTH-1:0];
    else if (x < DW_MIN) sat_dw = DW_MIN[DATA_WIDTH-1:0];
    else                 sat_dw = x[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [EXT_W-1:0] x);
    if (x > OW_MAX)      sat_out = OW_MAX[OUT_W-1:0];
    else if (x < OW_MIN) sat_out = OW_MIN[OUT_W-1:0];
    else                 sat_out = x[OUT_W-1:0];
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_add(
    input logic signed [DATA_WIDTH-1:0] a,
    input logic signed [DATA_WIDTH-1:0] b
  );
    logic signed [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      sat_add = s[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                              : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      sat_add = s[DATA_WIDTH-1:0];
    end
  endfunction

endpackage

@@ src/gather_along_axis_scatter_add_top.sv @@
// Top level: slab memory with gather, saturating scatter-add, load and drain.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------------------
//  s_*     | s_tvalid / s_tready       | s_tdata: position, axis_index, value; s_tuser: op
//  m_*     | m_tvalid / m_tready       | m_tdata: data_out; m_tuser: status
//  cfg_*   | cfg_valid / cfg_ready     | cfg_index (0 post_size, 1 axis_size), cfg_data
//
// Each request passes through these steps in order: accept, stride multiply, range check +
// RAM read, modify + RAM write + result. One request at a time; the registered multiply and
// the registered RAM read set that sequence.
// A new request is taken while a previous result still sits in the output register;
// the block stalls in the write-back cycle only when that register is still full.
// Reset (rst, synchronous) sets both sizes to 1; slab contents are not cleared.
// cfg_ready is always high.
module gather_along_axis_scatter_add_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [gaas_pkg::IN_DATA_W-1:0]      s_tdata,   // position[11:0], axis_index[23:12], value[55:24]
  input  logic [1:0]                          s_tuser,   // op[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [gaas_pkg::OUT_DATA_W-1:0]     m_tdata,   // data_out[31:0]
  output logic [1:0]                          m_tuser,   // status[1:0]
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gaas_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [gaas_pkg::CFG_W-1:0]          cfg_data
);

  gaas_pkg::state_t state;
  gaas_pkg::state_t state_next;

  logic [gaas_pkg::CFG_W-1:0] post_size;
  logic [gaas_pkg::CFG_W-1:0] axis_size;

  gaas_pkg::item_t item;
  gaas_pkg::chk_t  chk;
  gaas_pkg::chk_t  chk_q;

  logic                                     mul_en;
  logic                                     mem_re;
  logic                                     mem_we;
  logic signed [gaas_pkg::DATA_WIDTH-1:0]   mem_wdata;
  logic signed [gaas_pkg::DATA_WIDTH-1:0]   mem_rdata;
  logic signed [gaas_pkg::DATA_WIDTH-1:0]   val_sat;
  logic signed [gaas_pkg::OUT_W-1:0]        res_data;
  logic                                     out_free;
  logic                                     finish;
  logic                                     in_acc;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      post_size <= gaas_pkg::CFG_W'(1);
      axis_size <= gaas_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gaas_pkg::REG_POST_SIZE: post_size <= cfg_data;
        gaas_pkg::REG_AXIS_SIZE: axis_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture; held until write-back completes
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item.op         <= gaas_pkg::op_t'(s_tuser);
      item.position   <= s_tdata[gaas_pkg::POS_W-1:0];
      item.axis_index <= s_tdata[gaas_pkg::POS_W+gaas_pkg::IDX_W-1:gaas_pkg::POS_W];
      item.value      <= s_tdata[gaas_pkg::POS_W+gaas_pkg::IDX_W+gaas_pkg::VAL_W-1:
                                 gaas_pkg::POS_W+gaas_pkg::IDX_W];
    end
  end

  gaas_addr u_addr (
    .clk       (clk),
    .mul_en    (mul_en),
    .item      (item),
    .post_size (post_size),
    .axis_size (axis_size),
    .chk       (chk)
  );

  always_ff @(posedge clk) begin
    if (mem_re) begin
      chk_q <= chk;
    end
  end

  gaas_ram #(
    .DEPTH (gaas_pkg::SLAB_DEPTH),
    .WIDTH (gaas_pkg::DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (chk_q.addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (chk.addr),
    .rdata (mem_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gaas_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gaas_pkg::S_IDLE: if (s_tvalid) state_next = gaas_pkg::S_MUL;
      gaas_pkg::S_MUL:  state_next = gaas_pkg::S_CHK;
      gaas_pkg::S_CHK:  state_next = gaas_pkg::S_MOD;
      gaas_pkg::S_MOD:  if (out_free) state_next = gaas_pkg::S_IDLE;
      default:          state_next = gaas_pkg::S_IDLE;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    s_tready = 1'b0;
    mul_en   = 1'b0;
    mem_re   = 1'b0;
    finish   = 1'b0;
    case (state)
      gaas_pkg::S_IDLE: s_tready = 1'b1;
      gaas_pkg::S_MUL:  mul_en   = 1'b1;
      gaas_pkg::S_CHK:  mem_re   = 1'b1;
      gaas_pkg::S_MOD:  finish   = out_free;
      default: ;
    endcase
  end

  // read-modify-write datapath
  assign val_sat = gaas_pkg::sat_dw(gaas_pkg::EXT_W'(item.value));

  always_comb begin
    mem_wdata = '0;
    case (item.op)
      gaas_pkg::OP_LOAD:  mem_wdata = val_sat;
      gaas_pkg::OP_ACCUM: mem_wdata = gaas_pkg::sat_add(mem_rdata, val_sat);
      default:            mem_wdata = '0;   // drain clears the entry
    endcase
  end

  assign mem_we = finish && (chk_q.status == gaas_pkg::ST_OK) &&
                  (item.op != gaas_pkg::OP_GATHER);

  always_comb begin
    res_data = '0;
    if (chk_q.status == gaas_pkg::ST_OK &&
        (item.op == gaas_pkg::OP_GATHER || item.op == gaas_pkg::OP_DRAIN)) begin
      res_data = gaas_pkg::sat_out(gaas_pkg::EXT_W'(mem_rdata));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= gaas_pkg::OUT_DATA_W'(res_data);
      m_tuser <= chk_q.status;
    end
  end

  // no RAM write outside write-back
  a_we_in_mod: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == gaas_pkg::S_MOD)
    else $error("slab write outside write-back cycle");

  // an error never touches the slab
  a_no_we_on_err: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> chk_q.status == gaas_pkg::ST_OK)
    else $error("slab written on a range error");

  // error results carry zero data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    finish && chk_q.status != gaas_pkg::ST_OK |=> m_tdata == '0)
    else $error("nonzero data on error result");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    finish |-> !m_tvalid || m_tready)
    else $error("pending result overwritten");

  // accepted request always moves on to the multiply step
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == gaas_pkg::S_MUL)
    else $error("request accepted without starting");

endmodule

@@ src/gaas_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
module gaas_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/gaas_addr.sv @@
// Address unit: stride multiply (registered), then flat address and range checks.
module gaas_addr (
  input  logic                      clk,
  input  logic                      mul_en,
  input  gaas_pkg::item_t           item,
  input  logic [gaas_pkg::CFG_W-1:0] post_size,
  input  logic [gaas_pkg::CFG_W-1:0] axis_size,
  output gaas_pkg::chk_t            chk
);

  logic                          flat;
  logic [gaas_pkg::CFG_W-1:0]    mul_a;
  logic [gaas_pkg::PROD_W-1:0]   prod;
  logic                          idx_bad;
  logic                          pos_bad;
  logic [gaas_pkg::SUM_W-1:0]    sum;
  logic [gaas_pkg::SUM_W-1:0]    pos_ext;

  // load/drain check against axis_size*post_size, gather/accumulate need idx*post_size
  assign flat  = (item.op == gaas_pkg::OP_LOAD) || (item.op == gaas_pkg::OP_DRAIN);
  assign mul_a = flat ? axis_size : gaas_pkg::CFG_W'(item.axis_index);

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod    <= mul_a * post_size;
      idx_bad <= gaas_pkg::CFG_W'(item.axis_index) >= axis_size;
      pos_bad <= gaas_pkg::CFG_W'(item.position) >= post_size;
    end
  end

  assign pos_ext = gaas_pkg::SUM_W'(item.position);
  assign sum     = gaas_pkg::SUM_W'(prod) + pos_ext;

  always_comb begin
    chk.status = gaas_pkg::ST_OK;
    if (flat) begin
      chk.addr = gaas_pkg::ADDR_W'(item.position);
      if (pos_ext >= gaas_pkg::SUM_W'(prod) ||
          pos_ext >= gaas_pkg::SUM_W'(gaas_pkg::SLAB_DEPTH)) begin
        chk.status = gaas_pkg::ST_POS_BAD;
      end
    end else begin
      chk.addr = gaas_pkg::ADDR_W'(sum);
      if (idx_bad) begin
        chk.status = gaas_pkg::ST_AXIS_BAD;
      end else if (pos_bad || sum >= gaas_pkg::SUM_W'(gaas_pkg::SLAB_DEPTH)) begin
        chk.status = gaas_pkg::ST_POS_BAD;
      end
    end
  end

endmodule

@@ test/gaas_result_checker.sv @@
// Result checker: mirrors the slab memory and the size registers and compares every result.
module gaas_result_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [gaas_pkg::IN_DATA_W-1:0]  s_tdata,   // position[11:0], axis_index[23:12], value[55:24]
  input  logic [1:0]                      s_tuser,   // op[1:0]
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [gaas_pkg::OUT_DATA_W-1:0] m_tdata,   // data_out[31:0]
  input  logic [1:0]                      m_tuser,   // status[1:0]
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [gaas_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [gaas_pkg::CFG_W-1:0]      cfg_data,
  output int                              mismatches,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [gaas_pkg::OUT_W-1:0] data;
    gaas_pkg::status_t          status;
  } slab_result_t;

  slab_result_t                           expected_results[$];
  logic [gaas_pkg::CFG_W-1:0]             post_sz;
  logic [gaas_pkg::CFG_W-1:0]             axis_sz;
  logic signed [gaas_pkg::DATA_WIDTH-1:0] slab_mirror [gaas_pkg::SLAB_DEPTH];

  function automatic longint clamp(longint x, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Work out the result of one request and apply its side effect to the mirror.
  task automatic model_request(gaas_pkg::op_t op, logic [gaas_pkg::POS_W-1:0] pos,
                               logic [gaas_pkg::IDX_W-1:0] idx,
                               logic signed [gaas_pkg::VAL_W-1:0] val);
    slab_result_t r;
    longint       flat;
    longint       v;
    r.data   = '0;
    r.status = gaas_pkg::ST_OK;
    v = clamp(longint'(val), gaas_pkg::DATA_WIDTH);
    if (op == gaas_pkg::OP_LOAD || op == gaas_pkg::OP_DRAIN) begin
      flat = longint'(pos);
      if (flat >= longint'(axis_sz) * longint'(post_sz) || flat >= gaas_pkg::SLAB_DEPTH) begin
        r.status = gaas_pkg::ST_POS_BAD;
      end else if (op == gaas_pkg::OP_LOAD) begin
        slab_mirror[flat] = gaas_pkg::DATA_WIDTH'(v);
      end else begin
        r.data = gaas_pkg::OUT_W'(clamp(longint'(slab_mirror[flat]), gaas_pkg::OUT_W));
        slab_mirror[flat] = '0;
      end
    end else begin
      flat = longint'(idx) * longint'(post_sz) + longint'(pos);
      // axis index is checked ahead of position
      if (idx >= axis_sz) begin
        r.status = gaas_pkg::ST_AXIS_BAD;
      end else if (pos >= post_sz || flat >= gaas_pkg::SLAB_DEPTH) begin
        r.status = gaas_pkg::ST_POS_BAD;
      end else if (op == gaas_pkg::OP_GATHER) begin
        r.data = gaas_pkg::OUT_W'(clamp(longint'(slab_mirror[flat]), gaas_pkg::OUT_W));
      end else begin
        slab_mirror[flat] = gaas_pkg::DATA_WIDTH'(clamp(longint'(slab_mirror[flat]) + v,
                                                        gaas_pkg::DATA_WIDTH));
      end
    end
    expected_results.push_back(r);
  endtask

  task automatic check_result();
    slab_result_t r;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with no request outstanding: data %h status %0d",
                                m_tdata, m_tuser));
    end else begin
      r = expected_results.pop_front();
      if (m_tdata[gaas_pkg::OUT_W-1:0] !== r.data)
        report_mismatch($sformatf("data_out %h, expected %h",
                                  m_tdata[gaas_pkg::OUT_W-1:0], r.data));
      if (m_tuser !== r.status)
        report_mismatch($sformatf("status %0d, expected %0d", m_tuser, r.status));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      post_sz = gaas_pkg::CFG_W'(1);
      axis_sz = gaas_pkg::CFG_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gaas_pkg::REG_POST_SIZE: post_sz = cfg_data;
          gaas_pkg::REG_AXIS_SIZE: axis_sz = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        model_request(gaas_pkg::op_t'(s_tuser), s_tdata[gaas_pkg::POS_W-1:0],
                      s_tdata[gaas_pkg::POS_W +: gaas_pkg::IDX_W],
                      s_tdata[gaas_pkg::POS_W+gaas_pkg::IDX_W +: gaas_pkg::VAL_W]);
      if (m_tvalid && m_tready) check_result();
      pending = expected_results.size();
    end
  end

endmodule

@@ test/gather_along_axis_scatter_add_top_tb.sv @@
// Testbench top: drives requests and size writes into the slab block and reports the verdict.
module gather_along_axis_scatter_add_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Hang guard; the limit leaves a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 11;
  localparam int RAND_PER_PHASE = 120;
  localparam int PRELOAD_MAX = 32;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [gaas_pkg::IN_DATA_W-1:0]  s_tdata = '0;    // position[11:0], axis_index[23:12], value[55:24]
  logic [1:0]                      s_tuser = '0;    // op[1:0]
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [gaas_pkg::OUT_DATA_W-1:0] m_tdata;         // data_out[31:0]
  logic [1:0]                      m_tuser;         // status[1:0]
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [gaas_pkg::REG_IDX_W-1:0]  cfg_index = '0;
  logic [gaas_pkg::CFG_W-1:0]      cfg_data = '0;

  int mismatches;
  int pending;
  int cycles = 0;

  // Idle percentages for the current phase (sender gaps, receiver stalls).
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Sizes currently programmed, used only to shape legal stimulus.
  int cur_post = 1;
  int cur_axis = 1;

  // Flat entries loaded since reset; in-range reads of anything else are never issued.
  bit loaded [gaas_pkg::SLAB_DEPTH];
  int loaded_addrs[$];

  // Size settings per phase: small shapes, the reset shape, the 4096-long extremes,
  // zero sizes, the full 13-bit field and an exactly-full slab.
  int phase_post [NUM_PHASES] = '{1, 4, 16, 4096, 1, 3, 0, 7, 8191, 64, 13};
  int phase_axis [NUM_PHASES] = '{1, 8, 16, 1, 4096, 5, 7, 0, 8191, 64, 11};

  gather_along_axis_scatter_add_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gaas_result_checker result_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop if the run hangs or results go missing.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side backpressure, re-rolled every cycle.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Q16.16 values biased toward the saturation corners.
  function automatic logic [gaas_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return gaas_pkg::VAL_W'($urandom_range(32'h3_FFFF)) - 32'h2_0000;
      3:       return 32'h7FFF_0000 | gaas_pkg::VAL_W'($urandom_range(16'hFFFF));
      4:       return 32'h8000_0000 | gaas_pkg::VAL_W'($urandom_range(16'hFFFF));
      default: return gaas_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // One size register write; cfg_valid is left high for a back-to-back write.
  task automatic write_reg(logic [gaas_pkg::REG_IDX_W-1:0] idx, int v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= gaas_pkg::CFG_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Reprogram both sizes once every outstanding request has produced its result.
  task automatic set_sizes(int p, int a);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    write_reg(gaas_pkg::REG_POST_SIZE, p);
    write_reg(gaas_pkg::REG_AXIS_SIZE, a);
    cfg_valid <= 1'b0;
    cur_post = p;
    cur_axis = a;
  endtask

  // Send one request. A read of a never-loaded entry is turned into a load of
  // that entry, so the slab is only read where it holds defined data.
  task automatic drive_req(gaas_pkg::op_t op, logic [gaas_pkg::POS_W-1:0] pos,
                           logic [gaas_pkg::IDX_W-1:0] idx,
                           logic [gaas_pkg::VAL_W-1:0] val);
    int flat;
    bit hits;
    if (op == gaas_pkg::OP_LOAD || op == gaas_pkg::OP_DRAIN) begin
      flat = int'(pos);
      hits = (flat < cur_axis * cur_post);
    end else begin
      flat = int'(idx) * cur_post + int'(pos);
      hits = (int'(idx) < cur_axis) && (int'(pos) < cur_post) &&
             (flat < gaas_pkg::SLAB_DEPTH);
    end
    if (hits && op != gaas_pkg::OP_LOAD && !loaded[flat]) begin
      op  = gaas_pkg::OP_LOAD;
      pos = gaas_pkg::POS_W'(flat);
    end
    if (hits && op == gaas_pkg::OP_LOAD && !loaded[flat]) begin
      loaded[flat] = 1'b1;
      loaded_addrs.push_back(flat);
      if (loaded_addrs.size() > 256) void'(loaded_addrs.pop_front());
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= gaas_pkg::IN_DATA_W'({val, idx, pos});
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly well-formed requests into loaded entries, the rest range errors and noise.
  task automatic random_request();
    gaas_pkg::op_t              op;
    logic [gaas_pkg::POS_W-1:0] pos;
    logic [gaas_pkg::IDX_W-1:0] idx;
    int                         lim;
    int                         w;
    int                         mode;
    op   = gaas_pkg::op_t'($urandom_range(3));
    pos  = gaas_pkg::POS_W'($urandom);
    idx  = gaas_pkg::IDX_W'($urandom);
    mode = $urandom_range(99);
    lim  = (cur_axis * cur_post < gaas_pkg::SLAB_DEPTH) ? cur_axis * cur_post
                                                         : gaas_pkg::SLAB_DEPTH;
    if (mode < 80) begin
      if (lim > 0) begin
        if (loaded_addrs.size() > 0 && (op != gaas_pkg::OP_LOAD || $urandom_range(1) == 0))
          w = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
        else
          w = $urandom_range(lim - 1);
        // an entry loaded under an older shape may lie outside this one
        if (w < lim) begin
          if (op == gaas_pkg::OP_LOAD || op == gaas_pkg::OP_DRAIN) begin
            pos = gaas_pkg::POS_W'(w);
          end else begin
            idx = gaas_pkg::IDX_W'(w / cur_post);
            pos = gaas_pkg::POS_W'(w % cur_post);
          end
        end
      end
    end else if (mode < 88) begin
      // axis index past the bound
      if (cur_axis <= 4095) idx = gaas_pkg::IDX_W'($urandom_range(4095, cur_axis));
      if (cur_post > 0) pos = gaas_pkg::POS_W'($urandom_range(cur_post - 1));
    end else if (mode < 94) begin
      // position past the stride, or flat address past the shape
      if (op == gaas_pkg::OP_LOAD || op == gaas_pkg::OP_DRAIN) begin
        if (lim <= 4095) pos = gaas_pkg::POS_W'($urandom_range(4095, lim));
      end else begin
        if (cur_post <= 4095) pos = gaas_pkg::POS_W'($urandom_range(4095, cur_post));
        if (cur_axis > 0) idx = gaas_pkg::IDX_W'($urandom_range(cur_axis - 1));
      end
    end
    drive_req(op, pos, idx, rand_value());
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  initial begin
    int lim;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed pass on a 4 x 4 slab with no idling.
    set_sizes(4, 4);
    drive_req(gaas_pkg::OP_LOAD,   12'd0,    12'd0,    32'h7FFF_FFFF);
    drive_req(gaas_pkg::OP_LOAD,   12'd1,    12'd0,    32'h8000_0000);
    drive_req(gaas_pkg::OP_LOAD,   12'd2,    12'd0,    32'h0001_0000);
    drive_req(gaas_pkg::OP_LOAD,   12'd15,   12'd0,    32'hFFFF_8000);
    drive_req(gaas_pkg::OP_LOAD,   12'd16,   12'd0,    32'h1234_5678);  // just past the shape
    drive_req(gaas_pkg::OP_LOAD,   12'd4095, 12'd4095, 32'hFFFF_FFFF);
    drive_req(gaas_pkg::OP_GATHER, 12'd0,    12'd0,    32'h0);
    drive_req(gaas_pkg::OP_GATHER, 12'd1,    12'd0,    32'h0);
    drive_req(gaas_pkg::OP_GATHER, 12'd3,    12'd3,    32'h0);
    drive_req(gaas_pkg::OP_ACCUM,  12'd0,    12'd0,    32'h0000_0001);  // overflow to max
    drive_req(gaas_pkg::OP_ACCUM,  12'd1,    12'd0,    32'hFFFF_FFFF);  // underflow to min
    drive_req(gaas_pkg::OP_ACCUM,  12'd3,    12'd3,    32'h8000_0000);
    drive_req(gaas_pkg::OP_GATHER, 12'd0,    12'd0,    32'h0);
    drive_req(gaas_pkg::OP_GATHER, 12'd3,    12'd3,    32'h0);
    drive_req(gaas_pkg::OP_GATHER, 12'd0,    12'd4,    32'h0);          // axis index out of range
    drive_req(gaas_pkg::OP_GATHER, 12'd4,    12'd0,    32'h0);          // position out of range
    drive_req(gaas_pkg::OP_GATHER, 12'd4095, 12'd4095, 32'h0);          // both bad: axis wins
    drive_req(gaas_pkg::OP_ACCUM,  12'd0,    12'd4,    32'h0001_0000);
    drive_req(gaas_pkg::OP_ACCUM,  12'd4,    12'd1,    32'h0001_0000);
    drive_req(gaas_pkg::OP_DRAIN,  12'd0,    12'd0,    32'h0);          // read out and clear
    drive_req(gaas_pkg::OP_GATHER, 12'd0,    12'd0,    32'h0);
    drive_req(gaas_pkg::OP_DRAIN,  12'd16,   12'd0,    32'h0);
    drive_req(gaas_pkg::OP_DRAIN,  12'd4095, 12'd0,    32'h0);
    drive_req(gaas_pkg::OP_ACCUM,  12'd2,    12'd0,    32'hFFFB_0000);
    drive_req(gaas_pkg::OP_GATHER, 12'd2,    12'd0,    32'h0);

    // Random phases, one shape each, cycling through the idling modes.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_sizes(phase_post[ph], phase_axis[ph]);
      set_idling(ph);
      lim = phase_post[ph] * phase_axis[ph];
      if (lim > PRELOAD_MAX) lim = PRELOAD_MAX;
      // seed the start of the slab so reads land on real data early
      for (int a = 0; a < lim; a++)
        drive_req(gaas_pkg::OP_LOAD, gaas_pkg::POS_W'(a), gaas_pkg::IDX_W'($urandom),
                  rand_value());
      for (int n = 0; n < RAND_PER_PHASE; n++) random_request();
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
